// ----- hw/rtl/ntc_ot_pkg.sv -----
// Package for the oversampled NTC temperature block: widths, register indexes,
// reset values and status types shared by the back-end units.
// No dependencies.
package ntc_ot_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int SAMPLES_LOG2 = 5;
  localparam int SUM_W       = SAMPLE_W + SAMPLES_LOG2;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_W       = 26;
  localparam int L2_W        = 21;
  localparam int DIV_W       = 41;
  localparam int DIV_CNT_W   = 6;
  localparam int TEMP_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BETA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_REF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_REF = 3'd4;

  localparam logic [CFG_W-1:0] RST_BETA    = 16'd3950;
  localparam logic [CFG_W-1:0] RST_AMBIENT = 16'd29815;
  localparam logic [CFG_W-1:0] RST_ZERO    = 16'd27315;
  localparam logic [CFG_W-1:0] RST_ADC_REF = 16'd5000;
  localparam logic [CFG_W-1:0] RST_DIV_REF = 16'd5000;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [22:0] K_SCALE   = 23'd6553600;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

// ----- hw/rtl/ntc_ot_log2.sv -----
// Serial base-2 logarithm in Q16: one normalising shift per cycle, then one
// squaring step per fraction bit. Depends on ntc_ot_pkg.
module ntc_ot_log2 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ntc_ot_pkg::NUM_W-1:0] n_i,
  output ntc_ot_pkg::unit_st_t       st_o,
  output logic [ntc_ot_pkg::L2_W-1:0] l2_o
);
  import ntc_ot_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NORM = 2'd1;
  localparam logic [1:0] PH_SQ   = 2'd2;

  logic [1:0]  ph_q;
  logic [30:0] m_q;
  logic [4:0]  e_q;
  logic [15:0] fr_q;
  logic [3:0]  it_q;
  logic        done_q;
  logic [61:0] sq;
  logic [31:0] s;

  assign sq = m_q * m_q;
  assign s  = sq[61:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (ph_q)
        PH_IDLE: begin
          if (start_i) begin
            ph_q <= PH_NORM;
          end
        end
        PH_NORM: begin
          if (m_q[30]) begin
            ph_q <= PH_SQ;
            it_q <= '0;
          end
        end
        PH_SQ: begin
          it_q <= it_q + 4'd1;
          if (it_q == 4'd15) begin
            ph_q   <= PH_IDLE;
            done_q <= 1'b1;
          end
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          m_q  <= {5'd0, n_i};
          e_q  <= 5'd30;
          fr_q <= '0;
        end
      end
      PH_NORM: begin
        if (!m_q[30]) begin
          m_q <= {m_q[29:0], 1'b0};
          e_q <= e_q - 5'd1;
        end
      end
      PH_SQ: begin
        fr_q <= {fr_q[14:0], s[31]};
        m_q  <= s[31] ? s[31:1] : s[30:0];
      end
      default: ;
    endcase
  end

  assign st_o.busy = (ph_q != PH_IDLE);
  assign st_o.done = done_q;
  assign l2_o      = {e_q, fr_q};

endmodule

// ----- hw/rtl/ntc_ot_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on ntc_ot_pkg.
module ntc_ot_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ntc_ot_pkg::DIV_W-1:0] dividend_i,
  input  logic [ntc_ot_pkg::DIV_W-1:0] divisor_i,
  output ntc_ot_pkg::unit_st_t       st_o,
  output logic [ntc_ot_pkg::DIV_W-1:0] quot_o
);
  import ntc_ot_pkg::*;

  logic [DIV_W-1:0]     rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIV_W-1:0]     dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (start_i) begin
        rem_q <= '0;
        quo_q <= dividend_i;
        dsr_q <= divisor_i;
      end
    end else if (!diff[DIV_W]) begin
      rem_q <= diff[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], 1'b1};
    end else begin
      rem_q <= trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], 1'b0};
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign quot_o    = quo_q;

endmodule

// ----- hw/rtl/ntc_oversampled_temperature_top.sv -----
// Top level: per-channel 32-sample averaging and the NTC beta-equation back end.
// Depends on ntc_ot_pkg, ntc_ot_log2 and ntc_ot_div.
//
//   channel | direction | beat carries
//   in      | sink      | adc_sample, channel
//   out     | source    | result_channel, average_code, temperature_centi, out_of_range
//   cfg     | sink      | register index, 16-bit data (write only)
//
// A sample that does not complete an average is added to its channel's sum and the next sample can follow.
// A light result passes through the prep, check and output states after its last sample;
// a thermistor result goes through up to two log passes and two 41-step divisions.
// in_stall_o is high while a result is being worked out or waits for the output
// register; a stalled output beat holds. Reset clears sums and counts, sets the config registers to defaults.
module ntc_oversampled_temperature_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [ntc_ot_pkg::SAMPLE_W-1:0]       adc_sample_i,
  input  logic                                  channel_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  result_channel_o,
  output logic [ntc_ot_pkg::SAMPLE_W-1:0]       average_code_o,
  output logic signed [ntc_ot_pkg::TEMP_W-1:0]  temperature_centi_o,
  output logic                                  out_of_range_o,
  input  logic                                  cfg_we_i,
  input  logic [ntc_ot_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ntc_ot_pkg::CFG_W-1:0]          cfg_data_i
);
  import ntc_ot_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_LOGN = 4'd3;
  localparam logic [3:0] S_LOGD = 4'd4;
  localparam logic [3:0] S_LN   = 4'd5;
  localparam logic [3:0] S_TERM = 4'd6;
  localparam logic [3:0] S_DD   = 4'd7;
  localparam logic [3:0] S_TEMP = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [CFG_W-1:0] beta_q, amb_q, zero_q, vref_q, vdiv_q;
  logic [SUM_W-1:0] sum_q [2];
  logic [SAMPLES_LOG2-1:0] cnt_q [2];
  logic [3:0]  st_q;
  logic        ch_q;
  logic [SAMPLE_W-1:0] avg_q;
  logic [NUM_W-1:0] num_q;
  logic [38:0] k_q;
  logic [L2_W-1:0] l2n_q;
  logic signed [L2_W:0] d_q;
  logic signed [L2_W:0] lnx_q;
  logic signed [DIV_W:0] dd_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic        flag_q;
  logic        out_v_q;
  logic        in_acc;
  logic [SUM_W-1:0] sum_nx;
  logic signed [NUM_W:0] den;
  logic [CFG_W-1:0] ta;
  logic [L2_W-1:0] d_abs;
  logic [50:0] ln_prod;
  logic [L2_W-1:0] mag;
  logic signed [DIV_W:0] dd_w;
  logic signed [DIV_W:0] t_w;
  logic        log_start, div_start;
  logic [NUM_W-1:0] log_n;
  logic [DIV_W-1:0] div_a, div_b, quot;
  logic [L2_W-1:0] l2;
  unit_st_t    log_st, div_st;

  assign in_stall_o = (st_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sum_nx     = sum_q[channel_i] + SUM_W'(adc_sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= RST_BETA;
      amb_q  <= RST_AMBIENT;
      zero_q <= RST_ZERO;
      vref_q <= RST_ADC_REF;
      vdiv_q <= RST_DIV_REF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BETA:    beta_q <= cfg_data_i;
        REG_AMBIENT: amb_q  <= cfg_data_i;
        REG_ZERO:    zero_q <= cfg_data_i;
        REG_ADC_REF: vref_q <= cfg_data_i;
        REG_DIV_REF: vdiv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign den     = $signed({1'b0, vdiv_q, 10'd0}) - $signed({1'b0, num_q});
  assign ta      = (amb_q == '0) ? CFG_W'(1) : amb_q;
  assign d_abs   = d_q[L2_W] ? L2_W'(-d_q) : d_q[L2_W-1:0];
  assign ln_prod = d_abs * LN2_Q30;
  assign mag     = L2_W'((ln_prod + 51'(1 << 29)) >> 30);
  assign dd_w    = $signed({1'b0, quot}) +
                   $signed({{(DIV_W-L2_W){lnx_q[L2_W]}}, lnx_q});
  assign t_w     = $signed({1'b0, quot}) - $signed({26'd0, zero_q});

  assign log_start = ((st_q == S_CHK) && (ch_q == 1'b0) && (num_q != '0) &&
                       !den[NUM_W] && (den != '0)) ||
                     ((st_q == S_LOGN) && log_st.done);
  assign log_n     = (st_q == S_CHK) ? num_q : den[NUM_W-1:0];
  assign div_start = (st_q == S_LN) ||
                     ((st_q == S_DD) && !dd_q[DIV_W] && (dd_q != '0));
  assign div_a     = (st_q == S_LN) ? ({2'd0, k_q} + DIV_W'(ta >> 1))
                                    : ({2'd0, k_q} + dd_q[DIV_W:1]);
  assign div_b     = (st_q == S_LN) ? DIV_W'(ta) : dd_q[DIV_W-1:0];

  ntc_ot_log2 u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .n_i     (log_n),
    .st_o    (log_st),
    .l2_o    (l2)
  );

  ntc_ot_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .st_o       (div_st),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      out_v_q  <= 1'b0;
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
    end else begin
      if ((st_q == S_OUT) && (!out_v_q || !out_stall_i)) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            if (cnt_q[channel_i] == '1) begin
              sum_q[channel_i] <= '0;
              cnt_q[channel_i] <= '0;
              st_q             <= S_PREP;
            end else begin
              sum_q[channel_i] <= sum_nx;
              cnt_q[channel_i] <= cnt_q[channel_i] + 1'b1;
            end
          end
        end
        S_PREP: st_q <= S_CHK;
        S_CHK:  st_q <= log_start ? S_LOGN : S_OUT;
        S_LOGN: if (log_st.done) st_q <= S_LOGD;
        S_LOGD: if (log_st.done) st_q <= S_LN;
        S_LN:   st_q <= S_TERM;
        S_TERM: if (div_st.done) st_q <= S_DD;
        S_DD:   st_q <= div_start ? S_TEMP : S_OUT;
        S_TEMP: if (div_st.done) st_q <= S_OUT;
        S_OUT: begin
          if (!out_v_q || !out_stall_i) begin
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          ch_q  <= channel_i;
          avg_q <= sum_nx[SUM_W-1:SAMPLES_LOG2];
        end
      end
      S_PREP: begin
        num_q  <= avg_q * vref_q;
        k_q    <= beta_q * K_SCALE;
        temp_q <= '0;
        flag_q <= 1'b0;
      end
      S_CHK: begin
        if (!ch_q) begin
          if (num_q == '0) begin
            temp_q <= TEMP_MAX;
            flag_q <= 1'b1;
          end else if (den[NUM_W] || den == '0) begin
            temp_q <= TEMP_MIN;
            flag_q <= 1'b1;
          end
        end
      end
      S_LOGN: if (log_st.done) l2n_q <= l2;
      S_LOGD: if (log_st.done) d_q <= $signed({1'b0, l2n_q}) - $signed({1'b0, l2});
      S_LN:   lnx_q <= d_q[L2_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      S_TERM: if (div_st.done) dd_q <= dd_w;
      S_DD: begin
        if (!div_start) begin
          temp_q <= TEMP_MAX;
          flag_q <= 1'b1;
        end
      end
      S_TEMP: begin
        if (div_st.done) begin
          if (t_w > $signed(42'(32767))) begin
            temp_q <= TEMP_MAX;
            flag_q <= 1'b1;
          end else if (t_w < -$signed(42'(32768))) begin
            temp_q <= TEMP_MIN;
            flag_q <= 1'b1;
          end else begin
            temp_q <= t_w[TEMP_W-1:0];
          end
        end
      end
      S_OUT: begin
        if (!out_v_q || !out_stall_i) begin
          result_channel_o    <= ch_q;
          average_code_o      <= avg_q;
          temperature_centi_o <= temp_q;
          out_of_range_o      <= flag_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_v_q;

endmodule

// ----- hw/rtl/ntc_ot_checker.sv -----
// Port-level checker for the NTC temperature top level, bound to it below.
// Depends on ntc_ot_pkg.
module ntc_ot_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 result_channel_o,
  input logic signed [ntc_ot_pkg::TEMP_W-1:0] temperature_centi_o,
  input logic                                 out_of_range_o
);
  import ntc_ot_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(temperature_centi_o))
    else $error("stalled output beat dropped or changed");

  a_light_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_channel_o |-> temperature_centi_o == '0 && !out_of_range_o)
    else $error("light beat carries a temperature or flag");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after a sample");

endmodule

bind ntc_oversampled_temperature_top ntc_ot_checker u_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .result_channel_o    (result_channel_o),
  .temperature_centi_o (temperature_centi_o),
  .out_of_range_o      (out_of_range_o)
);
